FILE: rtl/lrncf_pkg.sv
// ----------------------------------------------------------------------------
// lrncf_pkg: shared constants and table builders for the LRN forward unit
// Holds fixed sizes, register codes, reset values, datapath widths and the
// elaboration-time functions that fill the log2 and exp2 lookup tables.
// ----------------------------------------------------------------------------
package lrncf_pkg;

	localparam int MAX_WINDOW     = 16;
	localparam int MAX_CHANNELS   = 4096;
	localparam int LOG_TABLE_SIZE = 64;
	localparam int VALUE_DEPTH    = 16;
	localparam int PRIOR_DEPTH    = 8;

	// table address widths: entry index and index plus one
	localparam int TAB_IW = $clog2(LOG_TABLE_SIZE);
	localparam int TAB_AW = $clog2(LOG_TABLE_SIZE + 1);
	localparam int LOG_W  = 17;
	localparam int EXP_W  = 18;

	// shared multiplier operand and product widths
	localparam int MUL_AW = 37;
	localparam int MUL_BW = 19;
	localparam int MUL_PW = 56;

	localparam logic [11:0] CHAN_MAX = (MAX_CHANNELS - 1 < 4095) ?
		12'(MAX_CHANNELS - 1) : 12'd4095;

	// configuration register indexes
	localparam logic [2:0] CFG_WINDOW = 3'd0;
	localparam logic [2:0] CFG_ALPHA  = 3'd1;
	localparam logic [2:0] CFG_BETA   = 3'd2;
	localparam logic [2:0] CFG_K      = 3'd3;
	localparam logic [2:0] CFG_SCALE  = 3'd4;
	localparam logic [2:0] CFG_BLEND  = 3'd5;

	localparam logic [4:0]  RST_WINDOW = 5'd5;
	localparam logic [31:0] RST_ALPHA  = 32'd85899;
	localparam logic [15:0] RST_BETA   = 16'd12288;
	localparam logic [31:0] RST_K      = 32'd131072;
	localparam logic [15:0] RST_SCALE  = 16'd256;
	localparam logic [15:0] RST_BLEND  = 16'd0;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bt;
		logic [63:0] vv;
		res = '0;
		bt  = 64'd1 << 62;
		vv  = v;
		for (int i = 0; i < 32; i++) begin
			if (bt > vv) bt = bt >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (bt != 0) begin
				if (vv >= res + bt) begin
					vv  = vv - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
		end
		return res;
	endfunction

	// log2(1 + i/T) in Q16.16, by repeated squaring
	function automatic logic [31:0] log_entry(input int i);
		logic [63:0] x;
		logic [63:0] r;
		if (i >= LOG_TABLE_SIZE) return 32'h0001_0000;
		x = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_SIZE);
		r = '0;
		for (int b = 0; b < 17; b++) begin
			x = (x * x) >> 30;
			r = r << 1;
			if (x >= (64'd2 << 30)) begin
				x = x >> 1;
				r = r | 64'd1;
			end
		end
		return 32'((r + 64'd1) >> 1);
	endfunction

	// exp2(i/T) in Q16.16, as a product of square roots of two
	function automatic logic [31:0] exp_entry(input int i);
		logic [63:0] roots [0:19];
		logic [63:0] f;
		logic [63:0] p;
		if (i >= LOG_TABLE_SIZE) return 32'h0002_0000;
		roots[0] = isqrt64(64'd1 << 61);
		for (int k = 1; k < 20; k++) roots[k] = isqrt64(roots[k-1] << 30);
		f = (64'(i) << 20) / LOG_TABLE_SIZE;
		p = 64'd1 << 30;
		for (int k = 0; k < 20; k++) begin
			if (f[19-k]) p = (p * roots[k]) >> 30;
		end
		return 32'((p + 64'd8192) >> 14);
	endfunction

endpackage

FILE: rtl/lrncf_mul.sv
// ----------------------------------------------------------------------------
// lrncf_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module lrncf_mul (
	input  logic                                clk,
	input  logic signed [lrncf_pkg::MUL_AW-1:0] a,
	input  logic signed [lrncf_pkg::MUL_BW-1:0] b,
	output logic signed [lrncf_pkg::MUL_PW-1:0] prod
);
	import lrncf_pkg::*;

	always_ff @(posedge clk) begin
		prod <= MUL_PW'(a) * MUL_PW'(b);
	end

endmodule

FILE: rtl/lrncf_rom.sv
// ----------------------------------------------------------------------------
// lrncf_rom: log2 and exp2 interpolation tables
// Returns the table entries at an index and at the index plus one.
// ----------------------------------------------------------------------------
module lrncf_rom (
	input  logic [lrncf_pkg::TAB_IW-1:0] idx,
	output logic [lrncf_pkg::LOG_W-1:0]  log_lo,
	output logic [lrncf_pkg::LOG_W-1:0]  log_hi,
	output logic [lrncf_pkg::EXP_W-1:0]  exp_lo,
	output logic [lrncf_pkg::EXP_W-1:0]  exp_hi
);
	import lrncf_pkg::*;

	logic [LOG_W-1:0]  log_rom [0:LOG_TABLE_SIZE];
	logic [EXP_W-1:0]  exp_rom [0:LOG_TABLE_SIZE];
	logic [TAB_AW-1:0] addr_lo;
	logic [TAB_AW-1:0] addr_hi;

	for (genvar g = 0; g <= LOG_TABLE_SIZE; g++) begin : g_tab
		assign log_rom[g] = LOG_W'(log_entry(g));
		assign exp_rom[g] = EXP_W'(exp_entry(g));
	end

	assign addr_lo = TAB_AW'(idx);
	assign addr_hi = TAB_AW'(idx) + TAB_AW'(1);
	assign log_lo  = log_rom[addr_lo];
	assign log_hi  = log_rom[addr_hi];
	assign exp_lo  = exp_rom[addr_lo];
	assign exp_hi  = exp_rom[addr_hi];

endmodule

FILE: rtl/lrn_cross_channel_forward_unit.sv
// ----------------------------------------------------------------------------
// lrn_cross_channel_forward_unit: cross-channel LRN, forward direction
// Normalizes each channel by its neighbors' energy and blends a prior output.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one channel word per handshake, channel 0 first, s_tlast on
//   the final channel of a spatial position. m_* returns one result word per
//   emitted channel, m_tlast on the final result of the position, m_tuser
//   set when the base or the output was clipped. cfg_* writes a register by
//   index; it is always ready and must only be used while the unit is idle.
//   Each result is computed from the N squares in its window (at most 16),
//   all by the single shared multiplier stepped by the sequencer below:
//   squares one per cycle, then base, log2, beta, exp2, two scalings and
//   the blend. A last word flushes every pending channel, up to eight
//   results one after another. s_tready is high only while the sequencer
//   waits for a word.
//   The result register parts the two sides: a new word is taken while a
//   result still waits, and a stalled m_tready holds the sequencer only when
//   it has the next result ready to load.
//   Reset clears the counters, the handshake state and the registers to
//   their defaults; the value windows need no clearing.
// ----------------------------------------------------------------------------
module lrn_cross_channel_forward_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] x_value, [31:16] prior_value
	input  logic        s_tlast,   // last_channel
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] y_value, [27:16] channel_index, zeros
	output logic        m_tuser,   // saturated
	output logic        m_tlast    // last_result
);
	import lrncf_pkg::*;

	localparam int LPW = 31 + TAB_IW;
	localparam int EPW = 16 + TAB_IW;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_START = 5'd1;
	localparam logic [4:0] ST_RANGE = 5'd2;
	localparam logic [4:0] ST_CNT   = 5'd3;
	localparam logic [4:0] ST_SQ    = 5'd4;
	localparam logic [4:0] ST_ALO   = 5'd5;
	localparam logic [4:0] ST_AHI   = 5'd6;
	localparam logic [4:0] ST_BASE  = 5'd7;
	localparam logic [4:0] ST_NORM  = 5'd8;
	localparam logic [4:0] ST_LIDX  = 5'd9;
	localparam logic [4:0] ST_LOGM  = 5'd10;
	localparam logic [4:0] ST_LOGA  = 5'd11;
	localparam logic [4:0] ST_BETA  = 5'd12;
	localparam logic [4:0] ST_EIDX  = 5'd13;
	localparam logic [4:0] ST_EXPM  = 5'd14;
	localparam logic [4:0] ST_EXPA  = 5'd15;
	localparam logic [4:0] ST_NEGM  = 5'd16;
	localparam logic [4:0] ST_SHF   = 5'd17;
	localparam logic [4:0] ST_FIN   = 5'd18;
	localparam logic [4:0] ST_OUT   = 5'd19;

	// configuration registers
	logic [4:0]         win_q;
	logic [31:0]        alpha_q;
	logic [15:0]        beta_q;
	logic [31:0]        k_q;
	logic signed [15:0] scale_q;
	logic signed [15:0] blend_q;

	// channel windows, ring-addressed by channel number
	logic signed [15:0] value_win_q [0:VALUE_DEPTH-1];
	logic signed [15:0] prior_win_q [0:PRIOR_DEPTH-1];

	// sequencer and position bookkeeping
	logic [4:0]  state_q;
	logic [2:0]  step_q;
	logic [31:0] cc_q;
	logic [3:0]  pend_q;
	logic        flush_q;

	// per-result working registers
	logic [31:0]        c_q;
	logic [31:0]        lo_q;
	logic [31:0]        hi_q;
	logic [3:0]         j_q;
	logic [4:0]         nsq_q;
	logic               sq_live_q;
	logic [35:0]        sum_q;
	logic [51:0]        tlo_q;
	logic               sat_q;
	logic [31:0]        nv_q;
	logic [4:0]         p_q;
	logic [TAB_IW-1:0]  idx_q;
	logic [30:0]        rem_q;
	logic signed [23:0] lg_q;
	logic signed [11:0] q_q;
	logic [17:0]        mag_q;
	logic               neg_q;
	logic signed [48:0] term_q;
	logic signed [15:0] y_q;

	// result register
	logic        m_valid_q;
	logic [15:0] y_out_q;
	logic [11:0] chan_out_q;
	logic        sat_out_q;
	logic        last_out_q;

	logic               in_acc;
	logic               out_load;
	logic [4:0]         win_n;
	logic [4:0]         half;
	logic [4:0]         dly;
	logic [3:0]         pend_inc;
	logic [3:0]         rd_idx;
	logic signed [15:0] rd_val;
	logic signed [15:0] prior_rd;

	logic signed [MUL_AW-1:0] mul_a;
	logic signed [MUL_BW-1:0] mul_b;
	logic signed [MUL_PW-1:0] prod_q;
	logic signed [MUL_PW-1:0] prod_neg;

	logic [LOG_W-1:0] log_lo;
	logic [LOG_W-1:0] log_hi;
	logic [EXP_W-1:0] exp_lo;
	logic [EXP_W-1:0] exp_hi;

	logic [31:0]        c_dly;
	logic [31:0]        cc_m1;
	logic [31:0]        span;
	logic [52:0]        t53;
	logic [37:0]        base38;
	logic [4:0]         sh;
	logic               top_zero;
	logic [LPW-1:0]     lprod;
	logic signed [23:0] lg_next;
	logic signed [MUL_PW-1:0] e_val;
	logic [EPW-1:0]     eprod;
	logic [17:0]        mag_next;
	logic [30:0]        ua;
	logic signed [12:0] s_amt;
	logic signed [12:0] l_amt;
	logic [86:0]        shl;
	logic [47:0]        term_mag;
	logic signed [48:0] t1;
	logic signed [49:0] tot;
	logic signed [41:0] y_full;
	logic signed [15:0] y_clip;
	logic               y_sat;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid & s_tready;
	assign out_load  = (state_q == ST_OUT) && (!m_valid_q || m_tready);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0, chan_out_q, y_out_q};
	assign m_tuser  = sat_out_q;
	assign m_tlast  = last_out_q;

	// window size clamped to 1..MAX_WINDOW, split around the center channel
	always_comb begin
		if (win_q == 5'd0) win_n = 5'd1;
		else if (win_q > 5'(MAX_WINDOW)) win_n = 5'(MAX_WINDOW);
		else win_n = win_q;
		half = win_n >> 1;
		dly  = win_n - half - 5'd1;
	end

	assign pend_inc = (pend_q == 4'(PRIOR_DEPTH)) ? pend_q : pend_q + 4'd1;

	// one read port on each window
	assign rd_idx   = (state_q == ST_SQ) ? j_q : c_q[3:0];
	assign rd_val   = value_win_q[rd_idx];
	assign prior_rd = prior_win_q[c_q[2:0]];

	lrncf_rom u_rom (
		.idx    (idx_q),
		.log_lo (log_lo),
		.log_hi (log_hi),
		.exp_lo (exp_lo),
		.exp_hi (exp_hi)
	);

	lrncf_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod_q)
	);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQ: begin
				mul_a = MUL_AW'(rd_val);
				mul_b = MUL_BW'(rd_val);
			end
			ST_ALO: begin
				mul_a = {1'b0, sum_q};
				mul_b = {3'b0, alpha_q[15:0]};
			end
			ST_AHI: begin
				mul_a = {1'b0, sum_q};
				mul_b = {3'b0, alpha_q[31:16]};
			end
			ST_LOGM: begin
				mul_a = {6'b0, rem_q};
				mul_b = {2'b0, log_hi - log_lo};
			end
			ST_BETA: begin
				mul_a = MUL_AW'(lg_q);
				mul_b = {3'b0, beta_q};
			end
			ST_EXPM: begin
				mul_a = {21'b0, rem_q[15:0]};
				mul_b = {1'b0, exp_hi - exp_lo};
			end
			ST_EXPA: begin
				mul_a = MUL_AW'(rd_val);
				mul_b = MUL_BW'(scale_q);
			end
			ST_NEGM: begin
				mul_a = {6'b0, ua};
				mul_b = {1'b0, mag_q};
			end
			ST_SHF: begin
				mul_a = MUL_AW'(prior_rd);
				mul_b = MUL_BW'(blend_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// datapath steps, each consuming at most one registered product
	always_comb begin
		c_dly = c_q + 32'(dly);
		cc_m1 = cc_q - 32'd1;
		span  = hi_q - lo_q;

		t53    = {1'b0, prod_q[51:0]} + 53'(tlo_q[51:16]);
		base38 = 38'(k_q) + 38'(t53[52:16]);

		sh       = 5'd16 >> step_q;
		top_zero = (nv_q & ~(32'hFFFF_FFFF >> sh)) == 32'd0;
		lprod    = LPW'(nv_q[30:0]) * LPW'(LOG_TABLE_SIZE);

		lg_next = (($signed({19'b0, p_q}) - 24'sd16) <<< 16)
			+ $signed({7'b0, log_lo}) + $signed({7'b0, prod_q[47:31]});

		prod_neg = -prod_q;
		e_val    = prod_neg >>> 14;
		eprod    = EPW'(e_val[15:0]) * EPW'(LOG_TABLE_SIZE);
		mag_next = 18'(exp_lo) + prod_q[33:16];

		ua = prod_q[MUL_PW-1] ? prod_neg[30:0] : prod_q[30:0];

		// scale the product by 2^(q-16), capping the magnitude at 2^40
		s_amt    = 13'sd16 - 13'(q_q);
		l_amt    = -s_amt;
		shl      = 87'(prod_q[47:0]) << l_amt[5:0];
		term_mag = '0;
		if (s_amt >= 13'sd48) begin
			term_mag = '0;
		end else if (s_amt > 13'sd0) begin
			term_mag = prod_q[47:0] >> s_amt[5:0];
		end else if (prod_q[47:0] != 48'd0) begin
			if (l_amt >= 13'sd40 || shl > (87'd1 << 40)) term_mag = 48'd1 << 40;
			else term_mag = shl[47:0];
		end
		t1 = neg_q ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});

		// add the signed blend term and round half up to Q8.8
		tot    = 50'(term_q) + 50'($signed(prod_q[31:0]));
		y_full = 42'((tot + 50'sd128) >>> 8);
		y_sat  = 1'b0;
		if (y_full > 42'sd32767) begin
			y_clip = 16'sh7FFF;
			y_sat  = 1'b1;
		end else if (y_full < -42'sd32768) begin
			y_clip = -16'sh8000;
			y_sat  = 1'b1;
		end else begin
			y_clip = y_full[15:0];
		end
	end

	// sequencer, position counters, result handshake and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			cc_q      <= '0;
			pend_q    <= '0;
			flush_q   <= 1'b0;
			m_valid_q <= 1'b0;
			win_q     <= RST_WINDOW;
			alpha_q   <= RST_ALPHA;
			beta_q    <= RST_BETA;
			k_q       <= RST_K;
			scale_q   <= RST_SCALE;
			blend_q   <= RST_BLEND;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_WINDOW: win_q   <= cfg_data[4:0];
					CFG_ALPHA:  alpha_q <= cfg_data;
					CFG_BETA:   beta_q  <= cfg_data[15:0];
					CFG_K:      k_q     <= cfg_data;
					CFG_SCALE:  scale_q <= cfg_data[15:0];
					CFG_BLEND:  blend_q <= cfg_data[15:0];
					default: ;
				endcase
			end

			if (out_load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cc_q    <= cc_q + 32'd1;
						pend_q  <= pend_inc;
						flush_q <= s_tlast;
						// emit once the newest channel completes a window
						if (s_tlast || 5'(pend_inc) > dly) state_q <= ST_START;
					end
				end
				ST_START: state_q <= ST_RANGE;
				ST_RANGE: state_q <= ST_CNT;
				ST_CNT:   state_q <= ST_SQ;
				ST_SQ: begin
					if (nsq_q == 5'd0 && !sq_live_q) state_q <= ST_ALO;
				end
				ST_ALO:  state_q <= ST_AHI;
				ST_AHI:  state_q <= ST_BASE;
				ST_BASE: begin
					step_q  <= '0;
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4) state_q <= ST_LIDX;
				end
				ST_LIDX: state_q <= ST_LOGM;
				ST_LOGM: state_q <= ST_LOGA;
				ST_LOGA: state_q <= ST_BETA;
				ST_BETA: state_q <= ST_EIDX;
				ST_EIDX: state_q <= ST_EXPM;
				ST_EXPM: state_q <= ST_EXPA;
				ST_EXPA: state_q <= ST_NEGM;
				ST_NEGM: state_q <= ST_SHF;
				ST_SHF:  state_q <= ST_FIN;
				ST_FIN:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						pend_q <= pend_q - 4'd1;
						if (flush_q && pend_q != 4'd1) begin
							state_q <= ST_START;
						end else begin
							// a flushed position restarts at channel 0
							if (flush_q) cc_q <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload: windows, result register and per-result working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			value_win_q[cc_q[3:0]] <= s_tdata[15:0];
			prior_win_q[cc_q[2:0]] <= s_tdata[31:16];
		end

		if (out_load) begin
			y_out_q    <= y_q;
			chan_out_q <= (c_q < 32'(CHAN_MAX)) ? c_q[11:0] : CHAN_MAX;
			sat_out_q  <= sat_q;
			last_out_q <= flush_q && pend_q == 4'd1;
		end

		unique case (state_q)
			ST_START: begin
				c_q   <= cc_q - 32'(pend_q);
				sat_q <= 1'b0;
			end
			ST_RANGE: begin
				lo_q <= (c_q >= 32'(half)) ? c_q - 32'(half) : 32'd0;
				hi_q <= (c_dly < cc_m1) ? c_dly : cc_m1;
			end
			ST_CNT: begin
				j_q       <= lo_q[3:0];
				sum_q     <= '0;
				sq_live_q <= 1'b0;
				if (hi_q < lo_q) nsq_q <= 5'd0;
				else if (span >= 32'd15) nsq_q <= 5'd16;
				else nsq_q <= span[4:0] + 5'd1;
			end
			ST_SQ: begin
				if (sq_live_q) sum_q <= sum_q + prod_q[35:0];
				sq_live_q <= (nsq_q != 5'd0);
				if (nsq_q != 5'd0) begin
					j_q   <= j_q + 4'd1;
					nsq_q <= nsq_q - 5'd1;
				end
			end
			ST_AHI: tlo_q <= prod_q[51:0];
			ST_BASE: begin
				p_q <= 5'd31;
				if (base38 > 38'h00_FFFF_FFFF) begin
					nv_q  <= 32'hFFFF_FFFF;
					sat_q <= 1'b1;
				end else if (base38 == 38'd0) begin
					nv_q  <= 32'd1;
					sat_q <= 1'b1;
				end else begin
					nv_q <= base38[31:0];
				end
			end
			ST_NORM: begin
				// halve the search window each step until bit 31 is set
				if (top_zero) begin
					nv_q <= nv_q << sh;
					p_q  <= p_q - sh;
				end
			end
			ST_LIDX: begin
				idx_q <= lprod[LPW-1:31];
				rem_q <= lprod[30:0];
			end
			ST_LOGA: lg_q <= lg_next;
			ST_EIDX: begin
				q_q   <= e_val[27:16];
				idx_q <= eprod[EPW-1:16];
				rem_q <= 31'(eprod[15:0]);
			end
			ST_EXPA: mag_q <= mag_next;
			ST_NEGM: neg_q <= prod_q[MUL_PW-1];
			ST_SHF:  term_q <= t1;
			ST_FIN: begin
				y_q <= y_clip;
				if (y_sat) sat_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// pending channels never exceed the prior window depth
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'(PRIOR_DEPTH))
		else $error("pending channel count above prior window depth");

	// normalization leaves the leading one at bit 31
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LIDX |-> nv_q[31])
		else $error("base not normalized before log lookup");

	// sixteen squares of Q8.8 values stay below 2^35
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ALO |-> !sum_q[35])
		else $error("square sum out of range");

	// the final result of a position clears the position counters
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load && flush_q && pend_q == 4'd1 |=> cc_q == 32'd0 && pend_q == 4'd0)
		else $error("position counters not cleared after last result");

endmodule

FILE: verif/lrn_cross_channel_forward_unit_tb.sv
// ----------------------------------------------------------------------------
// lrn_cross_channel_forward_unit_tb: self-checking bench for the LRN unit
// Streams channel words through the unit under several register settings
// and idle patterns. A bit-exact normalizer model predicts each result word,
// and the result stream is checked in order, field by field.
// ----------------------------------------------------------------------------
module lrn_cross_channel_forward_unit_tb;
	import lrncf_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [15:0] x_value, [31:16] prior_value
	logic        s_tlast;   // last_channel
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [15:0] y_value, [27:16] channel_index, zeros
	logic        m_tuser;   // saturated
	logic        m_tlast;   // last_result

	lrn_cross_channel_forward_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	typedef struct packed {
		logic [15:0] y;
		logic [11:0] ch;
		logic        sat;
		logic        last;
	} lrn_result_t;

	typedef struct {
		logic [15:0] x;
		logic [15:0] p;
		logic        last;
		bit          typed;   // expected word written out below
		lrn_result_t want;
	} stim_row_t;

	lrn_result_t pending_results[$];
	int          mismatches;
	int          s_idle_pct;
	int          r_idle_pct;
	int          rx_hold;

	// model copy of the registers
	logic [4:0]  win_reg;
	logic [31:0] alpha_reg;
	logic [15:0] beta_reg;
	logic [31:0] k_reg;
	logic [15:0] scale_reg;
	logic [15:0] blend_reg;

	// model copy of the channel state
	logic signed [15:0] value_ring [VALUE_DEPTH];
	logic signed [15:0] prior_ring [PRIOR_DEPTH];
	int unsigned        chan_cnt;
	int unsigned        next_out;

	longint log2_tab [LOG_TABLE_SIZE + 1];
	longint exp2_tab [LOG_TABLE_SIZE + 1];

	// ------------------------------------------------------------------------
	// Fixed-point helpers and table construction
	// ------------------------------------------------------------------------
	function automatic longint floor_div(longint a, longint d);
		if (a >= 0) return a / d;
		return -((-a + d - 1) / d);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bt;
		res = 0;
		bt  = 64'd1 << 62;
		while (bt > v) bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v   = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	task automatic fill_tables();
		longint unsigned roots [20];
		longint unsigned f;
		longint unsigned pr;
		longint unsigned xs;
		longint unsigned r;
		roots[0] = int_sqrt(64'd1 << 61);
		for (int k = 1; k < 20; k++) roots[k] = int_sqrt(roots[k-1] << 30);
		for (int i = 0; i < LOG_TABLE_SIZE; i++) begin
			f  = (longint'(i) << 20) / LOG_TABLE_SIZE;
			pr = 64'd1 << 30;
			for (int k = 0; k < 20; k++)
				if (f[19-k]) pr = (pr * roots[k]) >> 30;
			exp2_tab[i] = longint'((pr + 64'd8192) >> 14);
			// log2 of 1 + i/T by squaring, one result bit per pass
			xs = (64'd1 << 30) + ((longint'(i) << 30) / LOG_TABLE_SIZE);
			r  = 0;
			for (int b = 0; b < 17; b++) begin
				xs = (xs * xs) >> 30;
				r  = r << 1;
				if (xs >= (64'd2 << 30)) begin
					xs = xs >> 1;
					r  = r | 1;
				end
			end
			log2_tab[i] = longint'((r + 1) >> 1);
		end
		exp2_tab[LOG_TABLE_SIZE] = 64'd1 << 17;
		log2_tab[LOG_TABLE_SIZE] = 64'd1 << 16;
	endtask

	// ------------------------------------------------------------------------
	// Normalizer model
	// ------------------------------------------------------------------------
	function automatic void reset_model();
		win_reg   = RST_WINDOW;
		alpha_reg = RST_ALPHA;
		beta_reg  = RST_BETA;
		k_reg     = RST_K;
		scale_reg = RST_SCALE;
		blend_reg = RST_BLEND;
		for (int i = 0; i < VALUE_DEPTH; i++) value_ring[i] = '0;
		for (int i = 0; i < PRIOR_DEPTH; i++) prior_ring[i] = '0;
		chan_cnt = 0;
		next_out = 0;
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [31:0] data);
		case (idx)
			CFG_WINDOW: win_reg   = data[4:0];
			CFG_ALPHA:  alpha_reg = data;
			CFG_BETA:   beta_reg  = data[15:0];
			CFG_K:      k_reg     = data;
			CFG_SCALE:  scale_reg = data[15:0];
			CFG_BLEND:  blend_reg = data[15:0];
			default: ;
		endcase
	endfunction

	// normalize one channel with the window in force now
	function automatic lrn_result_t normalize_channel(int unsigned c, int unsigned dly,
			int unsigned half, bit last);
		lrn_result_t res;
		longint sum, t, base, frac, prodt, rem, mag, a, ua, lg, e, q, f, s, t1, tot, y;
		int unsigned lo, hi, idx;
		int p;
		bit sat;
		sat = 0;
		lo  = (c >= half) ? c - half : 0;
		hi  = (c + dly < chan_cnt - 1) ? c + dly : chan_cnt - 1;
		sum = 0;
		for (int unsigned j = lo; j <= hi && j - lo < VALUE_DEPTH; j++)
			sum += longint'(value_ring[j % VALUE_DEPTH]) * longint'(value_ring[j % VALUE_DEPTH]);

		t    = sum * longint'(alpha_reg[15:0]);
		t    = sum * longint'(alpha_reg[31:16]) + (t >> 16);
		base = longint'(k_reg) + (t >> 16);
		if (base > 64'hFFFF_FFFF) begin
			base = 64'hFFFF_FFFF;
			sat  = 1;
		end
		if (base == 0) begin
			base = 1;
			sat  = 1;
		end

		// log2 of the base: leading one position plus table fraction
		p = 31;
		while (p > 0 && base[p] == 1'b0) p--;
		frac  = (base << (31 - p)) & 64'h7FFF_FFFF;
		prodt = frac * LOG_TABLE_SIZE;
		idx   = int'(prodt >> 31);
		rem   = prodt & 64'h7FFF_FFFF;
		lg    = longint'(p - 16) * 65536 + log2_tab[idx]
		      + ((log2_tab[idx+1] - log2_tab[idx]) * rem) / (64'sd1 <<< 31);

		// exp2 of -beta * log2(base)
		e     = floor_div(-longint'(beta_reg) * lg, 16384);
		q     = floor_div(e, 65536);
		f     = e - q * 65536;
		prodt = f * LOG_TABLE_SIZE;
		idx   = int'(prodt >> 16);
		rem   = prodt & 64'hFFFF;
		mag   = exp2_tab[idx] + ((exp2_tab[idx+1] - exp2_tab[idx]) * rem) / 65536;

		a   = longint'($signed(scale_reg)) * longint'(value_ring[c % VALUE_DEPTH]);
		ua  = (a < 0) ? -a : a;
		mag = mag * ua;
		s   = 16 - q;
		if (s >= 48) mag = 0;
		else if (s > 0) mag = mag >> s;
		else if (mag != 0) begin
			// cap a huge normalized term before blending
			if (-s >= 40 || mag > ((64'sd1 <<< 40) >>> (-s))) mag = 64'sd1 <<< 40;
			else mag = mag <<< (-s);
		end
		t1  = (a < 0) ? -mag : mag;
		tot = t1 + longint'($signed(blend_reg)) * longint'(prior_ring[c % PRIOR_DEPTH]);
		y   = floor_div(tot + 128, 256);
		if (y > 32767) begin
			y   = 32767;
			sat = 1;
		end
		if (y < -32768) begin
			y   = -32768;
			sat = 1;
		end
		res.y    = y[15:0];
		res.ch   = (c < CHAN_MAX) ? c[11:0] : CHAN_MAX;
		res.sat  = sat;
		res.last = last;
		return res;
	endfunction

	// advance the model by one accepted channel word, queue its results
	function automatic int predict_channel(logic [15:0] x, logic [15:0] pr, logic last);
		int unsigned n, half, dly;
		int cnt;
		cnt = 0;
		n   = win_reg;
		if (n < 1) n = 1;
		if (n > MAX_WINDOW) n = MAX_WINDOW;
		half = n / 2;
		dly  = n - half - 1;
		value_ring[chan_cnt % VALUE_DEPTH] = x;
		prior_ring[chan_cnt % PRIOR_DEPTH] = pr;
		chan_cnt++;
		// drop a channel left too far behind
		if (chan_cnt - next_out > PRIOR_DEPTH) next_out = chan_cnt - PRIOR_DEPTH;
		if (last) begin
			while (next_out != chan_cnt && cnt < 8) begin
				pending_results.push_back(normalize_channel(next_out, dly, half,
					next_out + 1 == chan_cnt));
				next_out++;
				cnt++;
			end
			chan_cnt = 0;
			next_out = 0;
		end else if (chan_cnt - next_out > dly) begin
			pending_results.push_back(normalize_channel(next_out, dly, half, 1'b0));
			next_out++;
			cnt = 1;
		end
		return cnt;
	endfunction

	// ------------------------------------------------------------------------
	// Clock and time limit
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off when requested
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold  <= rx_hold - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= r_idle_pct);
		end
	end

	// compare every accepted result word with the oldest expectation
	always @(posedge clk) begin
		lrn_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: y=%h ch=%0d sat=%b last=%b",
						m_tdata[15:0], m_tdata[27:16], m_tuser, m_tlast);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[15:0] !== want.y || m_tdata[27:16] !== want.ch ||
						m_tdata[31:28] !== 4'b0 || m_tuser !== want.sat ||
						m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected y=%h ch=%0d sat=%b last=%b, got tdata=%h sat=%b last=%b",
							want.y, want.ch, want.sat, want.last, m_tdata, m_tuser, m_tlast);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	// offer one channel word, idle first at random, advance on the handshake
	task automatic send_channel(logic [15:0] x, logic [15:0] pr, logic last, output int n);
		while ($urandom_range(99) < s_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pr, x};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		n = predict_channel(x, pr, last);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
	endtask

	// hold the sender until every result is back, then let the unit settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	stim_row_t directed [14];

	initial begin
		int n;
		logic [15:0] xr;
		logic [4:0]  w;
		logic [31:0] al, kv;
		logic [15:0] be, sc, bl;

		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_WINDOW;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		m_tready   = 1'b0;
		rx_hold    = 0;
		s_idle_pct = 0;
		r_idle_pct = 0;
		mismatches = 0;
		fill_tables();
		reset_model();

		// zero input with the default blend of zero reads off as zero
		directed[0]  = '{16'h0000, 16'h0000, 1'b1, 1'b1, '{16'h0000, 12'd0, 1'b0, 1'b1}};
		directed[1]  = '{16'h0000, 16'h8000, 1'b1, 1'b1, '{16'h0000, 12'd0, 1'b0, 1'b1}};
		directed[2]  = '{16'h7FFF, 16'h7FFF, 1'b1, 1'b0, '0};
		directed[3]  = '{16'h8000, 16'h8000, 1'b1, 1'b0, '0};
		directed[4]  = '{16'h7FFF, 16'h0000, 1'b0, 1'b0, '0};
		directed[5]  = '{16'h8000, 16'h0001, 1'b0, 1'b0, '0};
		directed[6]  = '{16'h0001, 16'hFFFF, 1'b0, 1'b0, '0};
		directed[7]  = '{16'hFFFF, 16'h7FFF, 1'b0, 1'b0, '0};
		directed[8]  = '{16'h0100, 16'hFF00, 1'b0, 1'b0, '0};
		directed[9]  = '{16'hFF00, 16'h0000, 1'b0, 1'b0, '0};
		directed[10] = '{16'h7FFF, 16'h8000, 1'b1, 1'b0, '0};
		directed[11] = '{16'h5555, 16'hAAAA, 1'b0, 1'b0, '0};
		directed[12] = '{16'hAAAA, 16'h5555, 1'b0, 1'b0, '0};
		directed[13] = '{16'h1234, 16'h4321, 1'b1, 1'b0, '0};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: begin s_idle_pct = 82; r_idle_pct = 0;  end
				2: begin s_idle_pct = 0;  r_idle_pct = 82; end
				3, 5: begin s_idle_pct = 34; r_idle_pct = 34; end
				default: begin s_idle_pct = 0; r_idle_pct = 0; end
			endcase

			// settings: zero base, clipped base, huge term, oversize window, random
			if (ph > 0) begin
				case (ph)
					1: begin w = 5'd1;  al = 32'd0; be = 16'd0; kv = 32'd0;
						sc = 16'h7FFF; bl = 16'h8000; end
					2: begin w = 5'd16; al = 32'hFFFF_FFFF; be = 16'hFFFF; kv = 32'hFFFF_FFFF;
						sc = 16'h8000; bl = 16'h7FFF; end
					3: begin w = 5'd0;  al = 32'd1; be = 16'hFFFF; kv = 32'd1;
						sc = 16'h7FFF; bl = 16'h0000; end
					4: begin w = 5'd31; al = $urandom; be = 16'($urandom); kv = $urandom;
						sc = 16'($urandom); bl = 16'($urandom); end
					default: begin w = 5'($urandom_range(0, 31));
						al = $urandom >> $urandom_range(31);
						be = 16'($urandom); kv = $urandom; sc = 16'($urandom);
						bl = 16'($urandom); end
				endcase
				write_reg(CFG_WINDOW, {27'd0, w});
				write_reg(CFG_ALPHA, al);
				write_reg(CFG_BETA, {16'd0, be});
				write_reg(CFG_K, kv);
				write_reg(CFG_SCALE, {16'd0, sc});
				write_reg(CFG_BLEND, {16'd0, bl});
				cfg_valid <= 1'b0;
				@(posedge clk);
			end

			if (ph == 0) begin
				foreach (directed[i]) begin
					send_channel(directed[i].x, directed[i].p, directed[i].last, n);
					// swap in the written-out word for rows that carry one
					if (directed[i].typed && n == 1) begin
						void'(pending_results.pop_back());
						pending_results.push_back(directed[i].want);
					end
				end
			end

			// fill the unit against a long receiver hold-off
			if (ph == 4) rx_hold = 400;

			for (int i = 0; i < 20; i++) begin
				xr = 16'($urandom);
				if ($urandom_range(3) == 0) xr = $signed(xr) >>> $urandom_range(15);
				send_channel(xr, 16'($urandom), ($urandom_range(4) == 0), n);
			end
			drain();
		end

		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
